/* hdl/abre_pkg.sv */
// ----------------------------------------------------------------------------
// abre_pkg
// Shared types, constants and codes of the adaptive binary range encoder.
// ----------------------------------------------------------------------------
package abre_pkg;

    localparam int CONTEXTS  = 1024;
    localparam int CTX_W     = $clog2(CONTEXTS);
    localparam int PROB_BITS = 12;

    localparam logic [PROB_BITS:0]   PROB_ONE  = 13'h1000;
    localparam logic [PROB_BITS-1:0] PROB_MAX  = 12'hFFF;
    localparam logic [PROB_BITS-1:0] PROB_MIN  = 12'h001;
    localparam logic [PROB_BITS-1:0] PROB_INIT = 12'h800;

    localparam logic [31:0] RANGE_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] RENORM_TOP = 32'h0100_0000;
    localparam logic [31:0] LOW_TOP    = 32'hFF00_0000;
    localparam logic [31:0] PEND_MAX   = 32'hFFFF_FFFF;
    localparam logic [7:0]  CACHE_INIT = 8'hFF;
    localparam logic [7:0]  FILL_ONES  = 8'hFF;
    localparam logic [7:0]  FILL_ZEROS = 8'h00;

    localparam int SHIFT_CNT_W = 3;
    localparam logic [SHIFT_CNT_W-1:0] ENC_SHIFTS   = 3'd4;
    localparam logic [SHIFT_CNT_W-1:0] FLUSH_SHIFTS = 3'd5;

    localparam logic [1:0] FUNC_ENCODE = 2'd0;
    localparam logic [1:0] FUNC_FLUSH  = 2'd1;
    localparam logic [1:0] FUNC_LOAD   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic        bit_value;
        logic [9:0]  context_req;
        logic [3:0]  adapt_shift;
        logic [11:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  lead_byte;
        logic [31:0] filler_count;
        logic [7:0]  filler_byte;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_SHIFT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic multiply;
        logic update;
        logic shift_step;
        logic shift_range;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic range_low;
        logic can_step;
        logic fin_done;
    } stat_t;

endpackage

/* hdl/abre_ctrl.sv */
// ----------------------------------------------------------------------------
// abre_ctrl
// Sequencer: clearing pass, multiply, update, byte shifts and final release.
// ----------------------------------------------------------------------------
module abre_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  abre_pkg::stat_t        stat,
    output abre_pkg::cmd_t         cmd
);

    abre_pkg::state_t state_reg, state_next;
    logic [abre_pkg::SHIFT_CNT_W-1:0] cnt_reg, cnt_next;
    logic flush_reg, flush_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abre_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            abre_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = abre_pkg::ST_IDLE;
                end
            end
            abre_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    if (s_func == abre_pkg::FUNC_ENCODE) begin
                        flush_next = 1'b0;
                        state_next = abre_pkg::ST_MUL;
                    end else if (s_func == abre_pkg::FUNC_FLUSH) begin
                        flush_next = 1'b1;
                        state_next = abre_pkg::ST_SHIFT;
                    end
                end
            end
            abre_pkg::ST_MUL: begin
                cmd.multiply = 1'b1;
                state_next   = abre_pkg::ST_UPD;
            end
            abre_pkg::ST_UPD: begin
                cmd.update = 1'b1;
                state_next = abre_pkg::ST_SHIFT;
            end
            abre_pkg::ST_SHIFT: begin
                if (flush_reg ? (cnt_reg == abre_pkg::FLUSH_SHIFTS)
                              : (!stat.range_low || cnt_reg == abre_pkg::ENC_SHIFTS)) begin
                    state_next = abre_pkg::ST_FIN;
                end else begin
                    cmd.shift_step  = 1'b1;
                    cmd.shift_range = !flush_reg;
                    if (stat.can_step) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            abre_pkg::ST_FIN: begin
                cmd.finish = 1'b1;
                if (stat.fin_done) begin
                    state_next = abre_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = abre_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/abre_dpath.sv */
// ----------------------------------------------------------------------------
// abre_dpath
// Coder registers, probability memory, multiplier and result staging.
// ----------------------------------------------------------------------------
module abre_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  abre_pkg::in_item_t  s_payload,
    input  abre_pkg::cmd_t      cmd,
    output abre_pkg::stat_t     stat,
    input  logic                m_ready,
    output logic                m_valid,
    output abre_pkg::out_item_t m_payload
);

    logic [abre_pkg::PROB_BITS-1:0] prob_mem [abre_pkg::CONTEXTS];
    logic [abre_pkg::PROB_BITS-1:0] rdata_reg;
    logic [abre_pkg::CTX_W-1:0]     clr_cnt_reg;

    // Latched item.
    logic                           bit_reg;
    logic [3:0]                     sh_reg;
    logic [abre_pkg::CTX_W-1:0]     ctx_reg;

    logic [abre_pkg::PROB_BITS-1:0] prob_reg;
    logic [31:0]                    thr_reg;

    logic [31:0] range_reg, range_next;
    logic [32:0] low_reg, low_next;
    logic [7:0]  cache_reg, cache_next;
    logic [31:0] pend_reg, pend_next;

    abre_pkg::out_item_t hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;
    abre_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [abre_pkg::PROB_BITS-1:0] prob_fix;
    logic [abre_pkg::PROB_BITS:0]   prob_upd;
    logic [abre_pkg::PROB_BITS-1:0] prob_sat;
    logic [31:0] low32;
    logic        carry;
    logic        release_cond;
    logic        made;
    logic        out_free;
    logic        can_step;
    logic        step_go;
    logic        push_mid;
    logic        push_fin;
    abre_pkg::out_item_t run_item;

    // A stored zero probability would collapse the range; it is used as one.
    assign prob_fix = (rdata_reg == '0) ? abre_pkg::PROB_MIN : rdata_reg;

    always_comb begin
        if (!bit_reg) begin
            prob_upd = {1'b0, prob_reg} + ((abre_pkg::PROB_ONE - {1'b0, prob_reg}) >> sh_reg);
        end else begin
            prob_upd = {1'b0, prob_reg} - ({1'b0, prob_reg} >> sh_reg);
        end
        if (prob_upd > {1'b0, abre_pkg::PROB_MAX}) begin
            prob_sat = abre_pkg::PROB_MAX;
        end else if (prob_upd == '0) begin
            prob_sat = abre_pkg::PROB_MIN;
        end else begin
            prob_sat = prob_upd[abre_pkg::PROB_BITS-1:0];
        end
    end

    // Memory: one write port shared by the clearing pass, loads and updates.
    always_ff @(posedge aclk) begin
        rdata_reg <= prob_mem[s_payload.context_req[abre_pkg::CTX_W-1:0]];
        if (cmd.clear_step) begin
            prob_mem[clr_cnt_reg] <= abre_pkg::PROB_INIT;
        end else if (cmd.capture && s_payload.func == abre_pkg::FUNC_LOAD) begin
            prob_mem[s_payload.context_req[abre_pkg::CTX_W-1:0]] <= s_payload.load_value;
        end else if (cmd.update) begin
            prob_mem[ctx_reg] <= prob_sat;
        end
    end

    // Byte shift and run release.
    assign low32        = low_reg[31:0];
    assign carry        = low_reg[32];
    assign release_cond = (low32 < abre_pkg::LOW_TOP) || carry;
    assign made         = release_cond && (pend_reg != '0);
    assign out_free     = !out_valid_reg || m_ready;
    assign can_step     = !(made && hold_valid_reg && !out_free);
    assign step_go      = cmd.shift_step && can_step;
    assign push_mid     = step_go && made && hold_valid_reg;
    assign push_fin     = cmd.finish && hold_valid_reg && out_free;

    always_comb begin
        run_item.lead_byte    = cache_reg + {7'd0, carry};
        run_item.filler_count = pend_reg - 32'd1;
        run_item.filler_byte  = carry ? abre_pkg::FILL_ZEROS : abre_pkg::FILL_ONES;
        run_item.last         = 1'b0;
    end

    always_comb begin
        range_next = range_reg;
        low_next   = low_reg;
        cache_next = cache_reg;
        pend_next  = pend_reg;
        if (cmd.update) begin
            if (!bit_reg) begin
                range_next = thr_reg;
            end else begin
                range_next = range_reg - thr_reg;
                low_next   = low_reg + {1'b0, thr_reg};
            end
        end
        if (step_go) begin
            if (cmd.shift_range) begin
                range_next = {range_reg[23:0], 8'h00};
            end
            if (release_cond) begin
                cache_next = low32[31:24];
                pend_next  = 32'd1;
            end else if (pend_reg != abre_pkg::PEND_MAX) begin
                pend_next = pend_reg + 32'd1;
            end
            low_next = {1'b0, low32[23:0], 8'h00};
        end
    end

    // A run is held back one step so that the final run of a transaction
    // can be marked as last.
    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        if (push_mid) begin
            out_next       = hold_reg;
            out_valid_next = 1'b1;
        end else if (push_fin) begin
            out_next       = hold_reg;
            out_next.last  = 1'b1;
            out_valid_next = 1'b1;
        end
        if (step_go && made) begin
            hold_next       = run_item;
            hold_valid_next = 1'b1;
        end else if (push_fin) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg      <= abre_pkg::RANGE_INIT;
            low_reg        <= '0;
            cache_reg      <= abre_pkg::CACHE_INIT;
            pend_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
        end else begin
            range_reg      <= range_next;
            low_reg        <= low_next;
            cache_reg      <= cache_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
        if (cmd.capture) begin
            bit_reg <= s_payload.bit_value;
            sh_reg  <= s_payload.adapt_shift;
            ctx_reg <= s_payload.context_req[abre_pkg::CTX_W-1:0];
        end
        if (cmd.multiply) begin
            prob_reg <= prob_fix;
            thr_reg  <= 32'(range_reg[31:abre_pkg::PROB_BITS] * prob_fix);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == abre_pkg::CTX_W'(abre_pkg::CONTEXTS - 1));
    assign stat.range_low  = (range_reg < abre_pkg::RENORM_TOP);
    assign stat.can_step   = can_step;
    assign stat.fin_done   = !hold_valid_reg || out_free;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

`ifndef SYNTH
    // The carry is consumed by every byte shift.
    a_carry_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go |=> !low_reg[32])
        else $error("carry bit survived a byte shift");

    // After a split the range keeps at least one unit of probability weight.
    a_range_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (range_reg[31:abre_pkg::PROB_BITS] != '0))
        else $error("range collapsed after a split");

    // A byte shift always leaves at least one pending byte.
    a_pend_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go |=> (pend_reg != '0))
        else $error("pending count empty after a byte shift");

    // The final release empties the holding stage.
    a_fin_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && out_free) |=> !hold_valid_reg)
        else $error("held run not released at end of transaction");
`endif

endmodule

/* hdl/adaptive_binary_range_encoder_top.sv */
// ----------------------------------------------------------------------------
// adaptive_binary_range_encoder_top
// Adaptive binary range encoder with carry cache and byte-run results.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions on s_valid/s_ready carry an encode, flush or probability
// load request. Output transactions on m_valid/m_ready carry byte runs: a lead
// byte followed by filler_count filler bytes; last marks the final run of a
// request. Requests that release no run produce no output transaction.
// After reset the probability memory is cleared to one half, one entry per
// cycle; s_ready stays low until that pass ends. With an open receiver an
// encode steps through multiply, update, one step per byte shift (up to four),
// a step that ends the shifts, a release step and the idle state that accepts
// the next request. A flush runs five byte shifts and the release; a load or
// the unused code is taken in the idle state, which it does not leave.
// The sequencer handles one request at a time; the split multiply and the
// single write port of the probability memory set this sequence.
// A stalled receiver holds the run in the output register; further byte
// shifts that release a run wait until it is taken. A finished run may
// wait in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module adaptive_binary_range_encoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  abre_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output abre_pkg::out_item_t m_payload
);

    abre_pkg::cmd_t  cmd;
    abre_pkg::stat_t stat;

    abre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_payload.func),
        .stat    (stat),
        .cmd     (cmd)
    );

    abre_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule
